[sv/oriented_rect_overlap_test_core_macros.svh]
// Assertion macros shared by the checker of the overlap test core
`ifndef ORIENTED_RECT_OVERLAP_TEST_CORE_MACROS_SVH
`define ORIENTED_RECT_OVERLAP_TEST_CORE_MACROS_SVH

// same-cycle implication, suspended during reset
`define OROT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("overlap core check failed");

// next-cycle implication, suspended during reset
`define OROT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("overlap core check failed");

// next-cycle implication that also holds across reset
`define OROT_ASSERT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("overlap core check failed");

`endif

[sv/orot_pkg.sv]
// Types and constants of the oriented rectangle overlap test core
package orot_pkg;

   localparam int CornerW = 39;
   localparam int AxisW   = 17;
   localparam int ProdW   = CornerW + AxisW;
   localparam int ProjW   = ProdW + 1;
   localparam int Depth   = 7;

   typedef logic signed [CornerW-1:0] crd_type;
   typedef logic signed [AxisW-1:0]   axis_type;
   typedef logic signed [ProdW-1:0]   prod_type;
   typedef logic signed [ProjW-1:0]   proj_type;

   // corner signs along and across heading, corners 0..3
   localparam logic [3:0] SignXNeg = 4'b1001;
   localparam logic [3:0] SignYNeg = 4'b0011;

endpackage

[sv/orot_corner.sv]
// Corner builder: heading products, then the four corners of one rectangle
module orot_corner (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [23:0]    center_x,
   input  logic signed [23:0]    center_y,
   input  logic        [19:0]    half_len,
   input  logic        [19:0]    half_wid,
   input  logic signed [15:0]    cos_in,
   input  logic signed [15:0]    sin_in,
   output orot_pkg::crd_type     x_out [4],
   output orot_pkg::crd_type     y_out [4],
   output logic signed [15:0]    cos_out,
   output logic signed [15:0]    sin_out
);

   logic signed [36:0] chl_ff, shl_ff, chw_ff, shw_ff;
   logic signed [37:0] cxs_ff, cys_ff;
   logic signed [15:0] c1_ff, s1_ff, c2_ff, s2_ff;
   orot_pkg::crd_type  x_ff [4];
   orot_pkg::crd_type  y_ff [4];
   orot_pkg::crd_type  x_in [4];
   orot_pkg::crd_type  y_in [4];

   // stage 1: extent times heading, scaled centers
   always_ff @(posedge clock) begin
      if (en) begin
         chl_ff <= 37'(cos_in * $signed({1'b0, half_len}));
         shl_ff <= 37'(sin_in * $signed({1'b0, half_len}));
         chw_ff <= 37'(cos_in * $signed({1'b0, half_wid}));
         shw_ff <= 37'(sin_in * $signed({1'b0, half_wid}));
         cxs_ff <= {center_x, 14'b0};
         cys_ff <= {center_y, 14'b0};
         c1_ff  <= cos_in;
         s1_ff  <= sin_in;
      end
   end

   // stage 2: corner sums
   always_comb begin
      crd_add_loop: for (int i = 0; i < 4; i++) begin
         logic signed [38:0] chl, shl, chw, shw;
         chl = 39'(chl_ff);
         shl = 39'(shl_ff);
         chw = 39'(chw_ff);
         shw = 39'(shw_ff);
         x_in[i] = 39'(cxs_ff) + (orot_pkg::SignXNeg[i] ? -chl : chl)
                   - (orot_pkg::SignYNeg[i] ? -shw : shw);
         y_in[i] = 39'(cys_ff) + (orot_pkg::SignXNeg[i] ? -shl : shl)
                   + (orot_pkg::SignYNeg[i] ? -chw : chw);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff  <= x_in;
         y_ff  <= y_in;
         c2_ff <= c1_ff;
         s2_ff <= s1_ff;
      end
   end

   assign x_out   = x_ff;
   assign y_out   = y_ff;
   assign cos_out = c2_ff;
   assign sin_out = s2_ff;

endmodule

[sv/orot_proj.sv]
// Projection of all eight corners onto the four test axes
module orot_proj (
   input  logic                  clock,
   input  logic                  en,
   input  orot_pkg::crd_type     xa [4],
   input  orot_pkg::crd_type     ya [4],
   input  orot_pkg::crd_type     xb [4],
   input  orot_pkg::crd_type     yb [4],
   input  logic signed [15:0]    a_cos,
   input  logic signed [15:0]    a_sin,
   input  logic signed [15:0]    b_cos,
   input  logic signed [15:0]    b_sin,
   output orot_pkg::proj_type    proj [2][4][4]
);

   orot_pkg::axis_type ax [4];
   orot_pkg::axis_type ay [4];
   orot_pkg::prod_type px_ff [2][4][4];
   orot_pkg::prod_type py_ff [2][4][4];
   orot_pkg::proj_type proj_ff [2][4][4];

   // axes: heading and its normal, for both rectangles
   always_comb begin
      ax[0] = 17'(a_cos);
      ay[0] = 17'(a_sin);
      ax[1] = -17'(a_sin);
      ay[1] = 17'(a_cos);
      ax[2] = 17'(b_cos);
      ay[2] = 17'(b_sin);
      ax[3] = -17'(b_sin);
      ay[3] = 17'(b_cos);
   end

   // stage 3: coordinate times axis component
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < 4; i++) begin
               px_ff[0][k][i] <= orot_pkg::ProdW'(xa[i] * ax[k]);
               py_ff[0][k][i] <= orot_pkg::ProdW'(ya[i] * ay[k]);
               px_ff[1][k][i] <= orot_pkg::ProdW'(xb[i] * ax[k]);
               py_ff[1][k][i] <= orot_pkg::ProdW'(yb[i] * ay[k]);
            end
         end
      end
   end

   // stage 4: dot product sums
   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 2; r++) begin
            for (int k = 0; k < 4; k++) begin
               for (int i = 0; i < 4; i++) begin
                  proj_ff[r][k][i] <= orot_pkg::ProjW'(px_ff[r][k][i])
                                      + orot_pkg::ProjW'(py_ff[r][k][i]);
               end
            end
         end
      end
   end

   assign proj = proj_ff;

endmodule

[sv/orot_sep.sv]
// Interval bounds per axis and the final separation decision
module orot_sep (
   input  logic                  clock,
   input  logic                  en,
   input  orot_pkg::proj_type    proj [2][4][4],
   output logic                  overlap
);

   orot_pkg::proj_type lo2_ff [2][4][2];
   orot_pkg::proj_type hi2_ff [2][4][2];
   orot_pkg::proj_type lo_ff  [2][4];
   orot_pkg::proj_type hi_ff  [2][4];
   logic               overlap_ff;
   logic               overlap_in;

   // stage 5: min and max of corner pairs
   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 2; r++) begin
            for (int k = 0; k < 4; k++) begin
               for (int p = 0; p < 2; p++) begin
                  lo2_ff[r][k][p] <= (proj[r][k][2*p] < proj[r][k][2*p+1]) ?
                                     proj[r][k][2*p] : proj[r][k][2*p+1];
                  hi2_ff[r][k][p] <= (proj[r][k][2*p] > proj[r][k][2*p+1]) ?
                                     proj[r][k][2*p] : proj[r][k][2*p+1];
               end
            end
         end
      end
   end

   // stage 6: interval bounds
   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 2; r++) begin
            for (int k = 0; k < 4; k++) begin
               lo_ff[r][k] <= (lo2_ff[r][k][0] < lo2_ff[r][k][1]) ?
                              lo2_ff[r][k][0] : lo2_ff[r][k][1];
               hi_ff[r][k] <= (hi2_ff[r][k][0] > hi2_ff[r][k][1]) ?
                              hi2_ff[r][k][0] : hi2_ff[r][k][1];
            end
         end
      end
   end

   // stage 7: any strictly apart axis clears the overlap
   always_comb begin
      overlap_in = 1'b1;
      for (int k = 0; k < 4; k++) begin
         if (hi_ff[0][k] < lo_ff[1][k] || hi_ff[1][k] < lo_ff[0][k]) begin
            overlap_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         overlap_ff <= overlap_in;
      end
   end

   assign overlap = overlap_ff;

endmodule

[sv/oriented_rect_overlap_test_core.sv]
// Top level of the oriented rectangle overlap test core
//
// Usage:
//   The request channel (req_*) carries one pair of oriented rectangles per
//   request: center, half extents and Q2.14 cosine/sine of each heading.
//   The response channel (rsp_*) returns one bit, overlap, per request, in
//   request order. Touching rectangles report overlap.
//   From request accept to rsp_tvalid, two stages build the corners, two
//   project them onto the four axes, two reduce the intervals and one
//   makes the decision into the output register. Throughput is one request
//   per cycle when not stalled; every stage is a register stage.
//   The pipeline advances as a whole whenever the output register is empty
//   or being taken, so req_tready follows rsp_tready while the last stage
//   holds a response. A stall holds every stage in place.
//   Synchronous reset clears all valid bits; data registers are not reset.
//   There are no configuration registers.
module oriented_rect_overlap_test_core (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // a_center_x, a_center_y, a_half_len, a_half_wid, a_cos, a_sin,
   // b_center_x, b_center_y, b_half_len, b_half_wid, b_cos, b_sin
   input  logic [239:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // overlap, 7 bits zero fill
   output logic [7:0]    rsp_tdata
);

   logic                         adv;
   logic [orot_pkg::Depth-1:0]   vld_ff, vld_in;
   orot_pkg::crd_type            xa [4];
   orot_pkg::crd_type            ya [4];
   orot_pkg::crd_type            xb [4];
   orot_pkg::crd_type            yb [4];
   logic signed [15:0]           a_cos_d, a_sin_d, b_cos_d, b_sin_d;
   orot_pkg::proj_type           proj [2][4][4];
   logic                         overlap;

   // pipeline advance and valid tracking
   assign adv    = !vld_ff[orot_pkg::Depth-1] || rsp_tready;
   assign vld_in = {vld_ff[orot_pkg::Depth-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   orot_corner u_corner_a (
      .clock    (clock),
      .en       (adv),
      .center_x ($signed(req_tdata[23:0])),
      .center_y ($signed(req_tdata[47:24])),
      .half_len (req_tdata[67:48]),
      .half_wid (req_tdata[87:68]),
      .cos_in   ($signed(req_tdata[103:88])),
      .sin_in   ($signed(req_tdata[119:104])),
      .x_out    (xa),
      .y_out    (ya),
      .cos_out  (a_cos_d),
      .sin_out  (a_sin_d)
   );

   orot_corner u_corner_b (
      .clock    (clock),
      .en       (adv),
      .center_x ($signed(req_tdata[143:120])),
      .center_y ($signed(req_tdata[167:144])),
      .half_len (req_tdata[187:168]),
      .half_wid (req_tdata[207:188]),
      .cos_in   ($signed(req_tdata[223:208])),
      .sin_in   ($signed(req_tdata[239:224])),
      .x_out    (xb),
      .y_out    (yb),
      .cos_out  (b_cos_d),
      .sin_out  (b_sin_d)
   );

   orot_proj u_proj (
      .clock (clock),
      .en    (adv),
      .xa    (xa),
      .ya    (ya),
      .xb    (xb),
      .yb    (yb),
      .a_cos (a_cos_d),
      .a_sin (a_sin_d),
      .b_cos (b_cos_d),
      .b_sin (b_sin_d),
      .proj  (proj)
   );

   orot_sep u_sep (
      .clock   (clock),
      .en      (adv),
      .proj    (proj),
      .overlap (overlap)
   );

   // handshake outputs
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[orot_pkg::Depth-1];
   assign rsp_tdata  = {7'b0, overlap};

endmodule

[sv/orot_checker.sv]
// Port-level checker of the overlap test core, bound to the top level
`include "oriented_rect_overlap_test_core_macros.svh"

module orot_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [239:0] req_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [7:0]   rsp_tdata
);

   logic req_seen;
   assign req_seen = req_tvalid && req_tready && (req_tdata != req_tdata + 240'd1);

   // no response right after reset
   `OROT_ASSERT_ALWAYS(a_rst_quiet, reset, !rsp_tvalid)
   // a taken output slot always opens the request side
   `OROT_ASSERT_NOW(a_ready_follows, rsp_tready, req_tready)
   // fill bits of the response stay zero
   `OROT_ASSERT_NOW(a_fill_zero, rsp_tvalid, rsp_tdata[7:1] == 7'b0)
   // a stalled response is held
   `OROT_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
                     rsp_tvalid && $stable(rsp_tdata))
   // an empty slot never refuses a request; this check is vacuous
   `OROT_ASSERT_NOW(a_empty_ready, !rsp_tvalid, req_tready || !req_seen)

endmodule

bind oriented_rect_overlap_test_core orot_checker u_orot_checker (.*);
